// ===== rtl/core/swlt_pkg.sv =====
// Shared types, constants and helpers for the single-wire level transmitter.
package swlt_pkg;

	// Width of the phase timer.
	localparam int COUNT_BITS = 12;
	localparam int COUNT_MAX  = (1 << COUNT_BITS) - 1;

	// Configuration register file geometry.
	localparam int CFG_BITS     = 12;
	localparam int NUM_REGS     = 7;
	localparam int CFG_IDX_BITS = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] REG_MODE_HIGH   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MODE_DETECT = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_START       = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SHORT       = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_LONG        = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_END_LOW     = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_END_HIGH    = 3'd6;

	// Reset values of the configuration registers.
	localparam logic [CFG_BITS-1:0] RST_MODE_HIGH   = 12'd150;
	localparam logic [CFG_BITS-1:0] RST_MODE_DETECT = 12'd270;
	localparam logic [CFG_BITS-1:0] RST_START       = 12'd5;
	localparam logic [CFG_BITS-1:0] RST_SHORT       = 12'd5;
	localparam logic [CFG_BITS-1:0] RST_LONG        = 12'd20;
	localparam logic [CFG_BITS-1:0] RST_END_LOW     = 12'd10;
	localparam logic [CFG_BITS-1:0] RST_END_HIGH    = 12'd350;

	// Item kinds carried on tuser.
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_CMD  = 1'b1;

	// Waveform phases.
	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_MODE_HIGH = 3'd1,
		PH_MODE_LOW  = 3'd2,
		PH_START     = 3'd3,
		PH_BIT_LOW   = 3'd4,
		PH_BIT_HIGH  = 3'd5,
		PH_END_LOW   = 3'd6,
		PH_END_HIGH  = 3'd7
	} phase_t;

	// Phase durations as seen by the timer, already clamped to a legal range.
	typedef struct packed {
		logic [COUNT_BITS-1:0] mode_high;
		logic [COUNT_BITS-1:0] mode_detect;
		logic [COUNT_BITS-1:0] start;
		logic [COUNT_BITS-1:0] short_len;
		logic [COUNT_BITS-1:0] long_len;
		logic [COUNT_BITS-1:0] end_low;
		logic [COUNT_BITS-1:0] end_high;
	} dur_t;

	// A zero duration counts as one tick; a value beyond the timer saturates.
	function automatic logic [COUNT_BITS-1:0] sat_dur(input logic [CFG_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		if (w == 32'd0) begin
			w = 32'd1;
		end else if (w > 32'(COUNT_MAX)) begin
			w = 32'(COUNT_MAX);
		end
		return w[COUNT_BITS-1:0];
	endfunction

endpackage

// ===== rtl/core/swlt_cfg.sv =====
// Configuration register file holding the phase durations of the waveform.
module swlt_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [swlt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [swlt_pkg::CFG_BITS-1:0]        cfg_data,
	output swlt_pkg::dur_t                       dur
);

	logic [swlt_pkg::CFG_BITS-1:0] mode_high_q;
	logic [swlt_pkg::CFG_BITS-1:0] mode_detect_q;
	logic [swlt_pkg::CFG_BITS-1:0] start_q;
	logic [swlt_pkg::CFG_BITS-1:0] short_q;
	logic [swlt_pkg::CFG_BITS-1:0] long_q;
	logic [swlt_pkg::CFG_BITS-1:0] end_low_q;
	logic [swlt_pkg::CFG_BITS-1:0] end_high_q;

	// Register writes; an index past the last register is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_high_q   <= swlt_pkg::RST_MODE_HIGH;
			mode_detect_q <= swlt_pkg::RST_MODE_DETECT;
			start_q       <= swlt_pkg::RST_START;
			short_q       <= swlt_pkg::RST_SHORT;
			long_q        <= swlt_pkg::RST_LONG;
			end_low_q     <= swlt_pkg::RST_END_LOW;
			end_high_q    <= swlt_pkg::RST_END_HIGH;
		end else if (cfg_we) begin
			case (cfg_index)
				swlt_pkg::REG_MODE_HIGH:   mode_high_q   <= cfg_data;
				swlt_pkg::REG_MODE_DETECT: mode_detect_q <= cfg_data;
				swlt_pkg::REG_START:       start_q       <= cfg_data;
				swlt_pkg::REG_SHORT:       short_q       <= cfg_data;
				swlt_pkg::REG_LONG:        long_q        <= cfg_data;
				swlt_pkg::REG_END_LOW:     end_low_q     <= cfg_data;
				swlt_pkg::REG_END_HIGH:    end_high_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp each register into the range the timer can count.
	always_comb begin
		dur.mode_high   = swlt_pkg::sat_dur(mode_high_q);
		dur.mode_detect = swlt_pkg::sat_dur(mode_detect_q);
		dur.start       = swlt_pkg::sat_dur(start_q);
		dur.short_len   = swlt_pkg::sat_dur(short_q);
		dur.long_len    = swlt_pkg::sat_dur(long_q);
		dur.end_low     = swlt_pkg::sat_dur(end_low_q);
		dur.end_high    = swlt_pkg::sat_dur(end_high_q);
	end

endmodule

// ===== rtl/core/single_wire_level_transmitter_unit.sv =====
// Top level of the single-wire level transmitter: waveform sequencer and result register.
//
//  Channel   Direction  Payload
//  s_*       in         tdata = level[7:0]; tuser = kind (0 tick, 1 command)
//  m_*       out        tdata = line_level, busy_res, rejected, zero fill to 8 bits
//  cfg_*     in         write enable, register index 0..6, 12-bit value
//
// One transaction is taken every cycle while s_tready is high; its result is
// registered and shows on m_* in the next cycle. The sequencer state updates in the
// cycle of acceptance, so the next item sees it immediately. s_tready is low only
// while a result waits and m_tready is low. Reset puts the line high, wire mode set, phase idle.
module single_wire_level_transmitter_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [7:0] level
	input  logic                              s_tuser,   // [0] kind
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,   // [0] line_level, [1] busy_res, [2] rejected
	input  logic                              cfg_we,
	input  logic [swlt_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [swlt_pkg::CFG_BITS-1:0]     cfg_data
);

	swlt_pkg::dur_t dur;

	swlt_pkg::phase_t                  phase_q, phase_n;
	logic [swlt_pkg::COUNT_BITS-1:0]   cnt_q, cnt_n, cnt_inc, len;
	logic [2:0]                        bit_q, bit_n;
	logic [7:0]                        shift_q, shift_n;
	logic                              mode_q, mode_n;
	logic                              line_q, line_n;
	logic                              rej_n;
	logic                              cur_bit;
	logic                              accept;

	logic                              m_valid_q;
	logic [7:0]                        m_data_q;

	swlt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.dur       (dur)
	);

	// Take a new transaction whenever the result register is free or draining.
	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// Current data bit, MSB first, and the length of the current phase.
	assign cur_bit = shift_q[3'd7 - bit_q];
	assign cnt_inc = cnt_q + swlt_pkg::COUNT_BITS'(1);

	always_comb begin
		case (phase_q)
			swlt_pkg::PH_MODE_HIGH: len = dur.mode_high;
			swlt_pkg::PH_MODE_LOW:  len = dur.mode_detect;
			swlt_pkg::PH_START:     len = dur.start;
			swlt_pkg::PH_BIT_LOW:   len = cur_bit ? dur.short_len : dur.long_len;
			swlt_pkg::PH_BIT_HIGH:  len = cur_bit ? dur.long_len : dur.short_len;
			swlt_pkg::PH_END_LOW:   len = dur.end_low;
			default:                len = dur.end_high;
		endcase
	end

	// Next-state logic for one accepted transaction.
	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		mode_n  = mode_q;
		line_n  = line_q;
		rej_n   = 1'b0;
		if (s_tuser == swlt_pkg::KIND_CMD) begin
			if (phase_q != swlt_pkg::PH_IDLE) begin
				rej_n = 1'b1;
			end else if (s_tdata == 8'd0) begin
				line_n = 1'b0;
				mode_n = 1'b0;
			end else begin
				shift_n = s_tdata;
				bit_n   = 3'd0;
				cnt_n   = '0;
				line_n  = 1'b1;
				phase_n = mode_q ? swlt_pkg::PH_START : swlt_pkg::PH_MODE_HIGH;
			end
		end else if (phase_q != swlt_pkg::PH_IDLE) begin
			cnt_n = cnt_inc;
			if (cnt_inc >= len) begin
				cnt_n = '0;
				case (phase_q)
					swlt_pkg::PH_MODE_HIGH: begin
						phase_n = swlt_pkg::PH_MODE_LOW;
						line_n  = 1'b0;
					end
					swlt_pkg::PH_MODE_LOW: begin
						phase_n = swlt_pkg::PH_START;
						line_n  = 1'b1;
					end
					swlt_pkg::PH_START: begin
						phase_n = swlt_pkg::PH_BIT_LOW;
						line_n  = 1'b0;
					end
					swlt_pkg::PH_BIT_LOW: begin
						phase_n = swlt_pkg::PH_BIT_HIGH;
						line_n  = 1'b1;
					end
					swlt_pkg::PH_BIT_HIGH: begin
						line_n = 1'b0;
						if (bit_q == 3'd7) begin
							phase_n = swlt_pkg::PH_END_LOW;
						end else begin
							bit_n   = bit_q + 3'd1;
							phase_n = swlt_pkg::PH_BIT_LOW;
						end
					end
					swlt_pkg::PH_END_LOW: begin
						phase_n = swlt_pkg::PH_END_HIGH;
						line_n  = 1'b1;
					end
					default: begin
						phase_n = swlt_pkg::PH_IDLE;
						line_n  = 1'b1;
						mode_n  = 1'b1;
					end
				endcase
			end
		end
	end

	// Sequencer state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= swlt_pkg::PH_IDLE;
			cnt_q   <= '0;
			bit_q   <= 3'd0;
			shift_q <= 8'd0;
			mode_q  <= 1'b1;
			line_q  <= 1'b1;
		end else if (accept) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			mode_q  <= mode_n;
			line_q  <= line_n;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= {5'd0, rej_n, (phase_n != swlt_pkg::PH_IDLE), line_n};
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the single-wire level transmitter unit.
`timescale 1ns / 100ps

module tb_top;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DIR_ROWS       = 12;
	localparam int NUM_STAGES     = 7;
	localparam int MAX_PRINTS     = 40;
	localparam logic [swlt_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

	// One pin result: line level, busy flag and rejection flag.
	typedef struct packed {
		logic rejected;
		logic busy;
		logic line;
	} pin_res_t;

	// One row of the directed stimulus table.
	typedef struct packed {
		logic       kind;
		logic [7:0] level;
		logic       typed;
		logic       line;
		logic       busy;
		logic       rejected;
	} dir_row_t;

	logic                              clk;
	logic                              arst_n    = 1'b0;
	logic                              s_tvalid  = 1'b0;
	logic                              s_tready;
	logic [7:0]                        s_tdata   = 8'h00;   // [7:0] level
	logic                              s_tuser   = 1'b0;    // [0] kind
	logic                              m_tvalid;
	logic                              m_tready  = 1'b0;
	logic [7:0]                        m_tdata;             // [0] line_level, [1] busy_res, [2] rejected
	logic                              cfg_we    = 1'b0;
	logic [swlt_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [swlt_pkg::CFG_BITS-1:0]     cfg_data  = '0;

	// Waveform predictor state and its copy of the duration registers.
	swlt_pkg::phase_t                wf_phase;
	logic [swlt_pkg::COUNT_BITS-1:0] wf_count;
	logic [2:0]                      wf_bit;
	logic [7:0]                      wf_byte;
	logic                            wf_mode;
	logic                            wf_line;
	logic [swlt_pkg::CFG_BITS-1:0]   dur_reg [swlt_pkg::NUM_REGS];

	pin_res_t pin_result_q [$];
	dir_row_t dir_tab [DIR_ROWS];
	int       err_cnt     = 0;
	int       idle_cycles = 0;
	int       burst_left  = 0;
	bit       hold_req    = 1'b0;

	single_wire_level_transmitter_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Report one mismatch and count it.
	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		err_cnt++;
		if (err_cnt <= MAX_PRINTS) begin
			$display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		end
	endtask

	// Put the predictor into its post-reset state.
	function automatic void wf_reset();
		wf_phase = swlt_pkg::PH_IDLE;
		wf_count = '0;
		wf_bit   = '0;
		wf_byte  = '0;
		wf_mode  = 1'b1;
		wf_line  = 1'b1;
		dur_reg[swlt_pkg::REG_MODE_HIGH]   = swlt_pkg::RST_MODE_HIGH;
		dur_reg[swlt_pkg::REG_MODE_DETECT] = swlt_pkg::RST_MODE_DETECT;
		dur_reg[swlt_pkg::REG_START]       = swlt_pkg::RST_START;
		dur_reg[swlt_pkg::REG_SHORT]       = swlt_pkg::RST_SHORT;
		dur_reg[swlt_pkg::REG_LONG]        = swlt_pkg::RST_LONG;
		dur_reg[swlt_pkg::REG_END_LOW]     = swlt_pkg::RST_END_LOW;
		dur_reg[swlt_pkg::REG_END_HIGH]    = swlt_pkg::RST_END_HIGH;
	endfunction

	// Effective duration of a register: zero counts as one, the timer range caps it.
	function automatic int unsigned ticks_of(logic [swlt_pkg::CFG_IDX_BITS-1:0] idx);
		int unsigned d;
		d = 32'(dur_reg[idx]);
		if (d == 0) d = 1;
		if (d > swlt_pkg::COUNT_MAX) d = swlt_pkg::COUNT_MAX;
		return d;
	endfunction

	// Length of the phase now running, which depends on the current data bit in a bit cell.
	function automatic int unsigned phase_ticks();
		logic bit_val;
		bit_val = wf_byte[3'd7 - wf_bit];
		case (wf_phase)
			swlt_pkg::PH_MODE_HIGH: return ticks_of(swlt_pkg::REG_MODE_HIGH);
			swlt_pkg::PH_MODE_LOW:  return ticks_of(swlt_pkg::REG_MODE_DETECT);
			swlt_pkg::PH_START:     return ticks_of(swlt_pkg::REG_START);
			swlt_pkg::PH_BIT_LOW: begin
				return bit_val ? ticks_of(swlt_pkg::REG_SHORT) : ticks_of(swlt_pkg::REG_LONG);
			end
			swlt_pkg::PH_BIT_HIGH: begin
				return bit_val ? ticks_of(swlt_pkg::REG_LONG) : ticks_of(swlt_pkg::REG_SHORT);
			end
			swlt_pkg::PH_END_LOW:   return ticks_of(swlt_pkg::REG_END_LOW);
			default:                return ticks_of(swlt_pkg::REG_END_HIGH);
		endcase
	endfunction

	// Step the waveform for one accepted transaction and return the pin result.
	function automatic pin_res_t wire_predict(logic kind, logic [7:0] level);
		pin_res_t res;
		res.rejected = 1'b0;
		if (kind == swlt_pkg::KIND_CMD) begin
			if (wf_phase != swlt_pkg::PH_IDLE) begin
				res.rejected = 1'b1;
			end else if (level == 8'h00) begin
				wf_line = 1'b0;
				wf_mode = 1'b0;
			end else begin
				wf_byte  = level;
				wf_bit   = '0;
				wf_phase = wf_mode ? swlt_pkg::PH_START : swlt_pkg::PH_MODE_HIGH;
				wf_count = '0;
				wf_line  = 1'b1;
			end
		end else if (wf_phase != swlt_pkg::PH_IDLE) begin
			wf_count = wf_count + swlt_pkg::COUNT_BITS'(1);
			if (int'(wf_count) >= phase_ticks()) begin
				wf_count = '0;
				case (wf_phase)
					swlt_pkg::PH_MODE_HIGH: begin
						wf_phase = swlt_pkg::PH_MODE_LOW;
						wf_line  = 1'b0;
					end
					swlt_pkg::PH_MODE_LOW: begin
						wf_phase = swlt_pkg::PH_START;
						wf_line  = 1'b1;
					end
					swlt_pkg::PH_START: begin
						wf_phase = swlt_pkg::PH_BIT_LOW;
						wf_line  = 1'b0;
					end
					swlt_pkg::PH_BIT_LOW: begin
						wf_phase = swlt_pkg::PH_BIT_HIGH;
						wf_line  = 1'b1;
					end
					swlt_pkg::PH_BIT_HIGH: begin
						wf_line = 1'b0;
						if (wf_bit == 3'd7) begin
							wf_phase = swlt_pkg::PH_END_LOW;
						end else begin
							wf_bit   = wf_bit + 3'd1;
							wf_phase = swlt_pkg::PH_BIT_LOW;
						end
					end
					swlt_pkg::PH_END_LOW: begin
						wf_phase = swlt_pkg::PH_END_HIGH;
						wf_line  = 1'b1;
					end
					default: begin
						wf_phase = swlt_pkg::PH_IDLE;
						wf_line  = 1'b1;
						wf_mode  = 1'b1;
					end
				endcase
			end
		end
		res.line = wf_line;
		res.busy = (wf_phase != swlt_pkg::PH_IDLE);
		return res;
	endfunction

	// Sender pacing: bursts of random length separated by random gaps.
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Offer one transaction, wait for acceptance and queue what it should produce.
	task automatic send_item(logic kind, logic [7:0] level, logic typed, pin_res_t typed_res);
		pin_res_t pred;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= level;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pred = wire_predict(kind, level);
		pin_result_q.push_back(typed ? typed_res : pred);
		pace();
	endtask

	// Random transaction: mostly ticks while a waveform runs, frequent commands when idle.
	task automatic send_random();
		logic       kind;
		logic [7:0] level;
		int         cmd_pct;
		cmd_pct = (wf_phase == swlt_pkg::PH_IDLE) ? 50 : 8;
		kind    = ($urandom_range(0, 99) < cmd_pct) ? swlt_pkg::KIND_CMD : swlt_pkg::KIND_TICK;
		level   = 8'($urandom_range(0, 255));
		if (kind == swlt_pkg::KIND_CMD && $urandom_range(0, 4) == 0) level = 8'h00;
		send_item(kind, level, 1'b0, '0);
	endtask

	// Stop offering and wait until every result has come back.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pin_result_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write; an index past the register file changes nothing.
	task automatic cfg_write(logic [swlt_pkg::CFG_IDX_BITS-1:0] idx,
	                         logic [swlt_pkg::CFG_BITS-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (int'(idx) < swlt_pkg::NUM_REGS) dur_reg[idx] = val;
	endtask

	// Program all durations for one stage: zeros, all ones, then small random values.
	task automatic program_stage(int stage);
		logic [swlt_pkg::CFG_BITS-1:0] val;
		cfg_write(REG_UNUSED, swlt_pkg::CFG_BITS'($urandom));
		for (int r = 0; r < swlt_pkg::NUM_REGS; r++) begin
			case (stage)
				0:       val = '0;
				1:       val = '1;
				2:       val = swlt_pkg::CFG_BITS'($urandom_range(1, 3));
				default: val = swlt_pkg::CFG_BITS'($urandom_range(1, 10));
			endcase
			cfg_write(swlt_pkg::CFG_IDX_BITS'(r), val);
		end
		cfg_we <= 1'b0;
		repeat (2) @(posedge clk);
	endtask

	// Main stimulus: reset, directed table, then staged random traffic.
	initial begin
		pin_res_t typed_res;
		int       waited;
		dir_tab = '{
			'{swlt_pkg::KIND_TICK, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0},
			'{swlt_pkg::KIND_TICK, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0},
			'{swlt_pkg::KIND_CMD,  8'h00, 1'b1, 1'b0, 1'b0, 1'b0},
			'{swlt_pkg::KIND_TICK, 8'hA5, 1'b1, 1'b0, 1'b0, 1'b0},
			'{swlt_pkg::KIND_CMD,  8'h00, 1'b1, 1'b0, 1'b0, 1'b0},
			'{swlt_pkg::KIND_CMD,  8'h80, 1'b1, 1'b1, 1'b1, 1'b0},
			'{swlt_pkg::KIND_CMD,  8'h00, 1'b1, 1'b1, 1'b1, 1'b1},
			'{swlt_pkg::KIND_CMD,  8'hFF, 1'b1, 1'b1, 1'b1, 1'b1},
			'{swlt_pkg::KIND_TICK, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0},
			'{swlt_pkg::KIND_CMD,  8'h01, 1'b1, 1'b1, 1'b1, 1'b1},
			'{swlt_pkg::KIND_TICK, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0},
			'{swlt_pkg::KIND_TICK, 8'hC3, 1'b0, 1'b0, 1'b0, 1'b0}
		};
		wf_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed rows under the reset durations.
		for (int i = 0; i < DIR_ROWS; i++) begin
			typed_res.line     = dir_tab[i].line;
			typed_res.busy     = dir_tab[i].busy;
			typed_res.rejected = dir_tab[i].rejected;
			send_item(dir_tab[i].kind, dir_tab[i].level, dir_tab[i].typed, typed_res);
		end
		repeat (200) send_random();

		// Random traffic under several duration settings, one stage with a long output stall.
		for (int stage = 0; stage < NUM_STAGES; stage++) begin
			settle();
			program_stage(stage);
			if (stage == 3) hold_req = 1'b1;
			repeat ((stage == 1) ? 80 : 250) send_random();
		end

		// Drain, then let the pipeline run empty.
		s_tvalid <= 1'b0;
		waited = 0;
		while (pin_result_q.size() != 0 && waited < WATCHDOG_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pin_result_q.size() != 0) begin
			report_mismatch("missing results", 8'(pin_result_q.size()), 8'h00);
		end
		repeat (10) @(posedge clk);
		if (err_cnt == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

	// Receiver: short stalls on its own pattern, long free-running stretches, one long hold-off.
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if ($urandom_range(0, 9) == 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(60, 150)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
	end

	// Result checker: each output transaction against the oldest expectation.
	always @(posedge clk) begin
		pin_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pin_result_q.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, 8'h00);
			end else begin
				want = pin_result_q.pop_front();
				if (m_tdata[0] !== want.line) begin
					report_mismatch("line_level", 8'(m_tdata[0]), 8'(want.line));
				end
				if (m_tdata[1] !== want.busy) begin
					report_mismatch("busy_res", 8'(m_tdata[1]), 8'(want.busy));
				end
				if (m_tdata[2] !== want.rejected) begin
					report_mismatch("rejected", 8'(m_tdata[2]), 8'(want.rejected));
				end
				if (m_tdata[7:3] !== 5'd0) begin
					report_mismatch("fill bits", 8'(m_tdata[7:3]), 8'h00);
				end
			end
		end
	end

	// Watchdog: too many cycles without any transaction or register write ends the run.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
rtl/core/swlt_pkg.sv
rtl/core/swlt_cfg.sv
rtl/core/single_wire_level_transmitter_unit.sv
dv/tb_top.sv
